// ===== src/fcns_pkg.sv =====
// Package for the frame chord note segmenter.
// Holds shared widths, the slot cell control struct and the sequencer states.
package fcns_pkg;
   localparam int NoteBits   = 7;
   localparam int NoteFields = 10;
   localparam int CountBits  = 4;
   localparam int MinBits    = 10;
   localparam int OutFrameBits = 20;

   typedef logic [NoteBits-1:0] note_type;

   // Control broadcast from the sequencer to every slot cell
   typedef struct packed {
      logic shift_en;   // rotate contents one cell toward the head
      logic clear_head; // drop the head entry as it rotates
      logic load_tail;  // write a new note into the tail as it rotates
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT,
      ST_FLUSH,
      ST_ONSET,
      ST_ROT
   } state_type;
endpackage

// ===== src/frame_chord_note_segmenter.sv =====
// Frame chord note segmenter: slots form a ring of cells rotated toward cell 0.
// Each request is accepted in idle; then every note number 0..127 takes one ring lap
// plus an output step, which waits while a result is stalled; then a flush step and
// two ring laps per chord note for onsets (search, then place).
// Throughput: one request per pass, set by the single ring. Reset (synchronous,
// active high) clears all slot valid bits and sets the minimum duration to 2.
module frame_chord_note_segmenter #(
   parameter int MAX_NOTES  = 10,
   parameter int FRAME_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fcns_pkg::MinBits-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [19:0]                   req_frame_index,
   input  logic [3:0]                    req_note_count,
   input  logic [6:0]                    req_note_0,
   input  logic [6:0]                    req_note_1,
   input  logic [6:0]                    req_note_2,
   input  logic [6:0]                    req_note_3,
   input  logic [6:0]                    req_note_4,
   input  logic [6:0]                    req_note_5,
   input  logic [6:0]                    req_note_6,
   input  logic [6:0]                    req_note_7,
   input  logic [6:0]                    req_note_8,
   input  logic [6:0]                    req_note_9,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [6:0]                    rsp_ended_note,
   output logic [19:0]                   rsp_start_frame,
   output logic [19:0]                   rsp_duration_frames,
   output logic                          rsp_last_of_run
);
   import fcns_pkg::*;

   localparam int RotBits  = $clog2(MAX_NOTES + 1);
   localparam int CmpBits  = (FRAME_BITS > MinBits) ? FRAME_BITS : MinBits;

   state_type state_ff, state_in;
   logic [MinBits-1:0]    min_ff;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [CountBits-1:0]  count_ff, count_in;
   note_type              chord_ff [NoteFields];
   note_type              chord_in [NoteFields];
   logic [NoteBits:0]     scan_ff, scan_in;      // note being searched
   logic [3:0]            idx_ff, idx_in;        // chord note for onsets
   logic [RotBits-1:0]    rot_ff, rot_in;        // rotation steps done
   logic                  found_ff, found_in;    // match seen this rotation
   logic                  hit_ff, hit_in;        // held result candidate
   note_type              pn_ff, pn_in;
   logic [FRAME_BITS-1:0] ps_ff, ps_in;
   note_type              h_note_ff, h_note_in;
   logic [19:0]           h_start_ff, h_start_in, h_dur_ff, h_dur_in;
   logic                  o_valid_ff, o_valid_in;
   note_type              o_note_ff, o_note_in;
   logic [19:0]           o_start_ff, o_start_in, o_dur_ff, o_dur_in;
   logic                  o_last_ff, o_last_in;
   logic                  inc_ff, inc_in;        // note present in chord

   cell_ctrl_type         ctrl;
   logic                  c_valid [MAX_NOTES];
   note_type              c_note  [MAX_NOTES];
   logic [FRAME_BITS-1:0] c_start [MAX_NOTES];

   // Ring of slot cells: cell i takes from cell i+1, tail from head
   for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
      localparam int Nx = (g + 1) % MAX_NOTES;
      fcns_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
         .clock, .reset, .ctrl,
         .is_tail(g == MAX_NOTES - 1),
         .prev_valid(c_valid[Nx]), .prev_note(c_note[Nx]),
         .prev_start(c_start[Nx]),
         .load_note(chord_ff[idx_ff]), .load_start(frame_ff),
         .valid(c_valid[g]), .note(c_note[g]), .start(c_start[g]));
   end

   logic                  head_match;
   logic [FRAME_BITS-1:0] dur;
   logic                  last_step;
   logic                  cur_in_chord;
   logic                  rsp_free;
   logic                  qual;

   assign rsp_free     = !o_valid_ff || rsp_ready;
   assign last_step    = (rot_ff == RotBits'(MAX_NOTES - 1));
   assign dur          = frame_ff - ps_ff;
   // An ended note is reported when its wrapped duration reaches the minimum
   assign qual         = found_ff && (CmpBits'(dur) >= CmpBits'(min_ff));

   // Compare head cell against the current search key
   always_comb begin
      if (state_ff == ST_ONSET) begin
         head_match = c_valid[0] && (c_note[0] == chord_ff[idx_ff]);
      end else begin
         head_match = c_valid[0] && (c_note[0] == scan_ff[NoteBits-1:0]);
      end
   end

   // Membership of scan note among chord notes (independent compares)
   always_comb begin
      cur_in_chord = 1'b0;
      for (int i = 0; i < NoteFields; i++) begin
         if (4'(i) < count_ff && chord_ff[i] == scan_ff[NoteBits-1:0]) begin
            cur_in_chord = 1'b1;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      frame_in = frame_ff;
      count_in = count_ff;
      chord_in = chord_ff;
      scan_in = scan_ff;
      idx_in = idx_ff;
      rot_in = rot_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      pn_in = pn_ff;
      ps_in = ps_ff;
      h_note_in = h_note_ff;
      h_start_in = h_start_ff;
      h_dur_in = h_dur_ff;
      inc_in = inc_ff;
      o_valid_in = o_valid_ff && !rsp_ready;
      o_note_in = o_note_ff;
      o_start_in = o_start_ff;
      o_dur_in = o_dur_ff;
      o_last_in = o_last_ff;
      ctrl = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               frame_in = FRAME_BITS'(req_frame_index);
               count_in = (req_note_count > 4'(NoteFields)) ? 4'(NoteFields)
                                                            : req_note_count;
               chord_in[0] = req_note_0; chord_in[1] = req_note_1;
               chord_in[2] = req_note_2; chord_in[3] = req_note_3;
               chord_in[4] = req_note_4; chord_in[5] = req_note_5;
               chord_in[6] = req_note_6; chord_in[7] = req_note_7;
               chord_in[8] = req_note_8; chord_in[9] = req_note_9;
               scan_in = '0;
               rot_in = '0;
               found_in = 1'b0;
               hit_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rotate full ring; drop head if it holds the scan note and ends
            ctrl.shift_en = 1'b1;
            if (rot_ff == '0) inc_in = cur_in_chord;
            if (head_match && !(rot_ff == '0 ? cur_in_chord : inc_ff)) begin
               ctrl.clear_head = 1'b1;
               found_in = 1'b1;
               pn_in = c_note[0];
               ps_in = c_start[0];
            end
            rot_in = rot_ff + 1'b1;
            if (last_step) begin
               rot_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold a qualifying result; emit the held one once a new
            // one proves it was not last
            if (rsp_free) begin
               if (qual && hit_ff) begin
                  o_valid_in = 1'b1;
                  o_note_in = h_note_ff;
                  o_start_in = h_start_ff;
                  o_dur_in = h_dur_ff;
                  o_last_in = 1'b0;
               end
               if (qual) begin
                  hit_in = 1'b1;
                  h_note_in = pn_ff;
                  h_start_in = 20'(ps_ff);
                  h_dur_in = 20'(dur);
               end
               found_in = 1'b0;
               if (scan_ff == 8'(127)) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_in = scan_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            // send the held result as the last of the run
            if (rsp_free) begin
               if (hit_ff) begin
                  o_valid_in = 1'b1;
                  o_note_in = h_note_ff;
                  o_start_in = h_start_ff;
                  o_dur_in = h_dur_ff;
                  o_last_in = 1'b1;
                  hit_in = 1'b0;
               end
               idx_in = '0;
               state_in = (count_ff == '0) ? ST_IDLE : ST_ONSET;
            end
         end
         ST_ONSET: begin
            // rotate ring looking for the chord note already sounding
            ctrl.shift_en = 1'b1;
            if (head_match) found_in = 1'b1;
            rot_in = rot_ff + 1'b1;
            if (last_step) begin
               rot_in = '0;
               state_in = ST_ROT;
            end
         end
         default: begin // ST_ROT: one more lap placing the note in first free slot
            ctrl.shift_en = 1'b1;
            if (!found_ff && !c_valid[0]) begin
               // free slot at head: mark found and load when it reaches tail
               found_in = 1'b1;
               ctrl.load_tail = 1'b1;
               ctrl.clear_head = 1'b0;
            end
            rot_in = rot_ff + 1'b1;
            if (last_step) begin
               rot_in = '0;
               found_in = 1'b0;
               if (idx_ff + 1'b1 == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_ONSET;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff <= MinBits'(2);
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         o_valid_ff <= o_valid_in;
         if (csr_we) min_ff <= csr_wdata;
      end
      frame_ff <= frame_in; count_ff <= count_in; chord_ff <= chord_in;
      scan_ff <= scan_in; idx_ff <= idx_in; rot_ff <= rot_in;
      found_ff <= found_in; hit_ff <= (state_ff == ST_IDLE) ? 1'b0 : hit_in;
      pn_ff <= pn_in; ps_ff <= ps_in; inc_ff <= inc_in;
      h_note_ff <= h_note_in; h_start_ff <= h_start_in; h_dur_ff <= h_dur_in;
      o_note_ff <= o_note_in; o_start_ff <= o_start_in;
      o_dur_ff <= o_dur_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_ended_note = o_note_ff;
   assign rsp_start_frame = o_start_ff;
   assign rsp_duration_frames = o_dur_ff;
   assign rsp_last_of_run = o_last_ff;
endmodule

// ===== src/fcns_cell.sv =====
// One slot cell of the note ring: valid flag, note number and start frame.
// Depends on fcns_pkg for the control struct.
module fcns_cell #(
   parameter int FRAME_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fcns_pkg::cell_ctrl_type  ctrl,
   input  logic                     is_tail,
   input  logic                     prev_valid,
   input  fcns_pkg::note_type       prev_note,
   input  logic [FRAME_BITS-1:0]    prev_start,
   input  fcns_pkg::note_type       load_note,
   input  logic [FRAME_BITS-1:0]    load_start,
   output logic                     valid,
   output fcns_pkg::note_type       note,
   output logic [FRAME_BITS-1:0]    start
);
   import fcns_pkg::*;

   logic                  valid_ff, valid_in;
   note_type              note_ff, note_in;
   logic [FRAME_BITS-1:0] start_ff, start_in;

   // Take the neighbor's entry on a shift; the tail may load instead
   always_comb begin
      valid_in = valid_ff;
      note_in  = note_ff;
      start_in = start_ff;
      if (ctrl.shift_en) begin
         valid_in = prev_valid && !(is_tail && ctrl.clear_head);
         note_in  = prev_note;
         start_in = prev_start;
         if (is_tail && ctrl.load_tail) begin
            valid_in = 1'b1;
            note_in  = load_note;
            start_in = load_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      note_ff  <= note_in;
      start_ff <= start_in;
   end

   assign valid = valid_ff;
   assign note  = note_ff;
   assign start = start_ff;
endmodule

// ===== src/fcns_checker.sv =====
// Port-level checker for the frame chord note segmenter, bound to the top.
// Depends only on the top level's ports.
module fcns_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_start_frame,
   input logic [19:0] rsp_duration_frames
);
   // Hold a stalled response stable
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_frame) &&
      $stable(rsp_duration_frames))
      else $error("response dropped while stalled");

   // No new request taken in the cycle after one is taken
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Nothing to report right out of reset
   a_rst: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("response after reset");
endmodule

bind frame_chord_note_segmenter fcns_checker u_fcns_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_start_frame, .rsp_duration_frames);

// ===== bench/frame_chord_note_segmenter_test.sv =====
// Testbench for frame_chord_note_segmenter: directed table, then random frames.
// Depends on fcns_pkg and the segmenter RTL; predicts ended notes in-bench.
module frame_chord_note_segmenter_test;
   import fcns_pkg::*;

   localparam int Slots = 10;
   localparam int WatchLimit = 200000;
   localparam int DrainCycles = 2000;

   typedef struct {
      logic [19:0] frame;
      logic [3:0]  count;
      note_type    notes [NoteFields];
   } chord_type;

   typedef struct {
      note_type    note;
      logic [19:0] start;
      logic [19:0] dur;
      logic        last;
   } ended_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [MinBits-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [19:0] req_frame_index = '0;
   logic [3:0] req_note_count = '0;
   note_type req_note [NoteFields];
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [6:0] rsp_ended_note;
   logic [19:0] rsp_start_frame, rsp_duration_frames;
   logic rsp_last_of_run;

   // Predictor state
   logic          held_valid [Slots];
   note_type      held_note [Slots];
   logic [19:0]   held_start [Slots];
   logic [MinBits-1:0] min_frames;
   ended_type     ended_queue [$];

   int mismatches = 0;
   int idle_cycles = 0;
   bit rsp_calm = 0;
   bit done = 0;

   initial begin
      for (int i = 0; i < NoteFields; i++) req_note[i] = '0;
   end

   frame_chord_note_segmenter uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_frame_index(req_frame_index), .req_note_count(req_note_count),
      .req_note_0(req_note[0]), .req_note_1(req_note[1]), .req_note_2(req_note[2]),
      .req_note_3(req_note[3]), .req_note_4(req_note[4]), .req_note_5(req_note[5]),
      .req_note_6(req_note[6]), .req_note_7(req_note[7]), .req_note_8(req_note[8]),
      .req_note_9(req_note[9]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ended_note(rsp_ended_note),
      .rsp_start_frame(rsp_start_frame), .rsp_duration_frames(rsp_duration_frames),
      .rsp_last_of_run(rsp_last_of_run));

   initial begin
      forever #5 clock = ~clock;
   end

   // Clear held notes and restore the default minimum
   function automatic void segmenter_reset();
      min_frames = 2;
      for (int s = 0; s < Slots; s++) begin
         held_valid[s] = 0;
         held_note[s] = '0;
         held_start[s] = '0;
      end
   endfunction

   // Advance the held-note set by one chord and queue the notes that end
   function automatic void predict_ended(chord_type c);
      int cnt;
      int found;
      bit present;
      int first;
      cnt = (c.count > NoteFields) ? NoteFields : c.count;
      first = ended_queue.size();
      for (int n = 0; n < 128; n++) begin
         found = -1;
         for (int s = 0; s < Slots; s++)
            if (found < 0 && held_valid[s] && held_note[s] == n) found = s;
         present = 0;
         for (int i = 0; i < cnt; i++) if (c.notes[i] == n) present = 1;
         if (found >= 0 && !present) begin
            logic [19:0] dur;
            dur = c.frame - held_start[found];
            if (dur >= min_frames) begin
               ended_type e;
               e.note = note_type'(n);
               e.start = held_start[found];
               e.dur = dur;
               e.last = 0;
               ended_queue.insert(ended_queue.size(), e);
            end
            held_valid[found] = 0;
         end
      end
      if (ended_queue.size() > first) ended_queue[$].last = 1;
      for (int i = 0; i < cnt; i++) begin
         found = -1;
         for (int s = 0; s < Slots; s++)
            if (held_valid[s] && held_note[s] == c.notes[i]) found = s;
         if (found < 0) begin
            for (int s = 0; s < Slots; s++)
               if (found < 0 && !held_valid[s]) begin
                  found = s;
                  held_valid[s] = 1;
                  held_note[s] = c.notes[i];
                  held_start[s] = c.frame;
               end
         end
      end
   endfunction

   // Send one chord and hold it until accepted
   task automatic send_chord(chord_type c, bit may_idle);
      while (may_idle && $urandom_range(99) < 17) @(posedge clock);
      req_valid <= 1;
      req_frame_index <= c.frame;
      req_note_count <= c.count;
      for (int i = 0; i < NoteFields; i++) req_note[i] <= c.notes[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_ended(c);
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Wait for all expected results and an idle block, then settle
   task automatic drain();
      while (ended_queue.size() != 0 || !req_ready) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_min(logic [MinBits-1:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      min_frames = v;
   endtask

   function automatic chord_type make_chord(logic [19:0] f, int cnt, int n0, int n1,
                                            int n2);
      chord_type c;
      c.frame = f;
      c.count = 4'(cnt);
      for (int i = 0; i < NoteFields; i++) c.notes[i] = note_type'($urandom_range(127));
      c.notes[0] = note_type'(n0);
      c.notes[1] = note_type'(n1);
      c.notes[2] = note_type'(n2);
      return c;
   endfunction

   // Result side: random stall, compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ended_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected ended note %0d start %0d dur %0d",
                           rsp_ended_note, rsp_start_frame, rsp_duration_frames);
            end else begin
               ended_type e;
               e = ended_queue.pop_front();
               if (e.note !== rsp_ended_note || e.start !== rsp_start_frame ||
                   e.dur !== rsp_duration_frames || e.last !== rsp_last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              e.note, e.start, e.dur, e.last, rsp_ended_note,
                              rsp_start_frame, rsp_duration_frames, rsp_last_of_run);
               end
            end
         end
         rsp_ready <= rsp_calm ? 1'b1 : ($urandom_range(99) >= 17);
      end
   end

   // Watchdog on cycles with no accepted request or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit && !done) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Directed table: frame, count and first three notes per row
   typedef struct {
      logic [19:0] frame;
      int cnt;
      int n0, n1, n2;
   } row_type;

   row_type dir_table [11] = '{
      '{20'd0,      3, 0, 127, 60},
      '{20'd0,      3, 0, 127, 60},   // duplicates of sounding notes
      '{20'd1,      2, 0, 127, 0},    // 60 ends, duration 1 < 2: dropped
      '{20'd5,      0, 0, 0, 0},      // 0 and 127 end, duration 5
      '{20'd5,      15, 1, 2, 3},     // count above ten
      '{20'd10,     10, 1, 1, 1},     // duplicates within one frame
      '{20'd12,     0, 0, 0, 0},
      '{20'hFFFFF,  1, 64, 0, 0},
      '{20'd3,      0, 0, 0, 0},      // decreasing index: wrapped duration
      '{20'd3,      1, 64, 0, 0},
      '{20'd3,      0, 0, 0, 0}       // zero duration
   };

   initial begin
      chord_type c;
      logic [19:0] f;
      segmenter_reset();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Walk the directed table at reset minimum; check a readable row by hand
      rsp_calm = 1;
      foreach (dir_table[r]) begin
         c = make_chord(dir_table[r].frame, dir_table[r].cnt, dir_table[r].n0,
                        dir_table[r].n1, dir_table[r].n2);
         send_chord(c, 0);
         if (r == 3) begin
            if (ended_queue.size() != 2 || ended_queue[0].note != 0 ||
                ended_queue[0].dur != 5 || ended_queue[1].note != 127 ||
                ended_queue[1].last != 1) begin
               mismatches++;
               $display("directed row 3 prediction off");
            end
         end
      end
      drain();
      write_min(0);
      c = make_chord(20'd20, 0, 0, 0, 0);
      send_chord(c, 0);
      c = make_chord(20'd20, 1, 9, 0, 0);
      send_chord(c, 0);
      c = make_chord(20'd20, 0, 0, 0, 0);
      send_chord(c, 0);
      drain();
      write_min(10'd1023);
      c = make_chord(20'd30, 1, 50, 0, 0);
      send_chord(c, 0);
      c = make_chord(20'd1053, 0, 0, 0, 0);
      send_chord(c, 0);
      drain();
      rsp_calm = 0;

      // Random phases with several minima; small note pools keep notes sounding
      f = 20'd2000;
      for (int ph = 0; ph < 4; ph++) begin
         write_min(ph == 0 ? 10'd1 : ph == 1 ? 10'd3 : ph == 2 ? 10'h2AA : 10'd0);
         for (int k = 0; k < 70; k++) begin
            int pool;
            rsp_calm = (ph == 1 && k < 40);
            pool = ($urandom_range(99) < 80) ? 12 : 127;
            if ($urandom_range(99) < 5) f = 20'($urandom);
            else f = 20'(f + $urandom_range(ph == 2 ? 700 : 4));
            c.frame = f;
            c.count = ($urandom_range(99) < 8) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(10));
            for (int i = 0; i < NoteFields; i++)
               c.notes[i] = (pool == 127) ? note_type'($urandom_range(127)) :
                            note_type'(60 + $urandom_range(pool));
            send_chord(c, !rsp_calm);
            if (k == 35) drain();
         end
         drain();
      end

      done = 1;
      if (mismatches == 0 && ended_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
